@@ hw/rtl/sdbw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdbw_pkg
// Shared constants, types and the character-to-segment encoder of the
// seven-segment digit buffer writer.
// ----------------------------------------------------------------------------
package sdbw_pkg;

  localparam int DIGITS  = 24;
  localparam int DIG_AW  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int POS_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int CFG_W   = 5;
  localparam int CFG_IW  = 2;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_BLINK_ENABLE = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_BLINK_FIRST  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_BLINK_LAST   = 2'd2;

  // Item commands
  localparam logic CMD_CHAR     = 1'b0;
  localparam logic CMD_TRIANGLE = 1'b1;

  // Mark bits
  localparam logic [BYTE_W-1:0] TRI_BIT   = 8'h10;
  localparam logic [BYTE_W-1:0] COMMA_BIT = 8'h10;
  localparam logic [BYTE_W-1:0] DOT_BIT   = 8'h08;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  localparam logic [6:0] OTHER_PAT = 7'h18;

  typedef logic [6:0] seg_pat_t;

  // One store entry: segment bytes and blink copy bytes
  typedef struct packed {
    logic [BYTE_W-1:0] seg_lo;
    logic [BYTE_W-1:0] seg_hi;
    logic [BYTE_W-1:0] blk_lo;
    logic [BYTE_W-1:0] blk_hi;
  } digit_entry_t;

  localparam seg_pat_t NUM_PAT [10] = '{
    7'h7D, 7'h60, 7'h3E, 7'h7A, 7'h63, 7'h5B, 7'h5F, 7'h71, 7'h7F, 7'h7B
  };

  localparam seg_pat_t ALPHA_PAT [26] = '{
    7'h77, 7'h4F, 7'h1D, 7'h6E, 7'h1F, 7'h17, 7'h5D, 7'h67, 7'h40, 7'h6C,
    7'h07, 7'h0D, 7'h56, 7'h46, 7'h4E, 7'h37, 7'h73, 7'h06, 7'h5B, 7'h0F,
    7'h6D, 7'h4C, 7'h5C, 7'h1A, 7'h6B, 7'h3E
  };

  function automatic seg_pat_t char_pattern(input logic [7:0] c);
    seg_pat_t p;
    logic [7:0] d_idx;
    logic [7:0] l_idx;
    logic [7:0] u_idx;
    d_idx = c - 8'h30;
    l_idx = c - 8'h61;
    u_idx = c - 8'h41;
    case (c) inside
      [8'h30:8'h39]: p = NUM_PAT[d_idx[3:0]];
      [8'h61:8'h7A]: p = ALPHA_PAT[l_idx[4:0]];
      [8'h41:8'h5A]: p = ALPHA_PAT[u_idx[4:0]];
      8'h5F:         p = 7'h08;  // underscore
      8'h2D:         p = 7'h02;  // minus
      8'h20:         p = 7'h00;  // space
      8'h01:         p = 7'h08;  // cursor
      8'h00:         p = 7'h00;  // NUL
      default:       p = OTHER_PAT;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/sdbw_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdbw_in_if
// Item channel into the digit buffer writer: valid/ready plus item fields.
// ----------------------------------------------------------------------------
interface sdbw_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [sdbw_pkg::POS_W-1:0]    digit_pos;
  logic [7:0]                    char_code;
  logic                          mark_on;

  modport source (output valid, cmd, digit_pos, char_code, mark_on, input ready);
  modport sink   (input valid, cmd, digit_pos, char_code, mark_on, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/sdbw_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdbw_out_if
// Result channel of the digit buffer writer: valid/ready plus result fields.
// ----------------------------------------------------------------------------
interface sdbw_out_if;
  logic                          valid;
  logic                          ready;
  logic [sdbw_pkg::POS_W-1:0]    out_pos;
  logic [sdbw_pkg::BYTE_W-1:0]   seg_low;
  logic [sdbw_pkg::BYTE_W-1:0]   seg_high;
  logic [sdbw_pkg::BYTE_W-1:0]   blink_low;
  logic [sdbw_pkg::BYTE_W-1:0]   blink_high;
  logic                          range_error;

  modport source (output valid, out_pos, seg_low, seg_high, blink_low, blink_high,
                  range_error, input ready);
  modport sink   (input valid, out_pos, seg_low, seg_high, blink_low, blink_high,
                  range_error, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/seven_segment_digit_buffer_writer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seven_segment_digit_buffer_writer_core
// Digit store of a seven-segment panel with a blink copy, updated per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one beat per item (cmd, digit_pos, char_code, mark_on). A
//            character item encodes char_code into the digit; a triangle
//            item sets or clears the triangle bit of the digit.
//   out_ch : one beat per item with the digit's store and blink bytes after
//            the update, or range_error with zero bytes for a bad position.
//   cfg_*  : write blink_enable, blink_first, blink_last while idle.
// Result: the item is registered together with the entry read, and the result
//   beat is loaded into the output register once that register is free.
// Ordering: the entry memory is read when the item is accepted and, for a
//   valid position, written back when its result beat is loaded, so items
//   are handled one at a time through this read-modify-write.
// Reset: control state clears and every digit reads as zero until written
//   (a per-entry valid bit masks the memory, no clearing pass is needed).
// Stall: a finished beat sits in the output register; the next item is
//   still taken, and its write-back waits until the output slot frees.
// ----------------------------------------------------------------------------
module seven_segment_digit_buffer_writer_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  sdbw_in_if.sink                            in_ch,
  sdbw_out_if.source                         out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [sdbw_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [sdbw_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RMW  = 1'b1;

  localparam int AW = sdbw_pkg::DIG_AW;
  localparam int PW = sdbw_pkg::POS_W;

  // Configuration
  logic                       blink_en_r;
  logic [sdbw_pkg::CFG_W-1:0] blink_first_r;
  logic [sdbw_pkg::CFG_W-1:0] blink_last_r;

  // Control
  logic state_r, state_nxt;

  // Item held during the read-modify-write
  logic          item_cmd_r;
  logic [PW-1:0] item_pos_r;
  logic [7:0]    item_char_r;
  logic          item_on_r;
  logic          item_err_r;

  // Entry memory and its valid bits
  sdbw_pkg::digit_entry_t mem [sdbw_pkg::DIGITS];
  sdbw_pkg::digit_entry_t rdata_r;
  logic                   rd_ok_r;
  logic [sdbw_pkg::DIGITS-1:0] valid_r;

  // Output register
  logic                   out_valid_r, out_valid_nxt;
  logic [PW-1:0]          out_pos_r;
  sdbw_pkg::digit_entry_t out_ent_r;
  logic                   out_err_r;

  logic                   in_acc;
  logic                   in_range;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  logic                   slot_free;
  logic                   finish;
  logic                   wr_en;
  sdbw_pkg::digit_entry_t cur;
  sdbw_pkg::digit_entry_t upd;
  sdbw_pkg::seg_pat_t     pat;
  logic                   in_blink;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_range    = (in_ch.digit_pos < PW'(sdbw_pkg::DIGITS));
  assign rd_addr     = in_ch.digit_pos[AW-1:0];
  assign wr_addr     = item_pos_r[AW-1:0];
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign finish      = (state_r == ST_RMW) && slot_free;
  assign wr_en       = finish && !item_err_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_en_r    <= 1'b0;
      blink_first_r <= '0;
      blink_last_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sdbw_pkg::CFG_BLINK_ENABLE: blink_en_r    <= cfg_wdata[0];
        sdbw_pkg::CFG_BLINK_FIRST:  blink_first_r <= cfg_wdata;
        sdbw_pkg::CFG_BLINK_LAST:   blink_last_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Memory: registered read on accept, write-back on finish
  always_ff @(posedge clk) begin
    if (in_acc && in_range) begin
      rdata_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (in_acc) begin
        rd_ok_r <= in_range && valid_r[rd_addr];
      end
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  // Hold the item for the write-back cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_cmd_r  <= in_ch.cmd;
      item_pos_r  <= in_ch.digit_pos;
      item_char_r <= in_ch.char_code;
      item_on_r   <= in_ch.mark_on;
      item_err_r  <= !in_range;
    end
  end

  // Entry update
  always_comb begin
    cur      = rd_ok_r ? rdata_r : '0;
    upd      = cur;
    pat      = sdbw_pkg::char_pattern(item_char_r);
    in_blink = (item_pos_r >= PW'(blink_first_r)) && (item_pos_r <= PW'(blink_last_r));
    if (item_cmd_r == sdbw_pkg::CMD_CHAR) begin
      upd.seg_hi = cur.seg_hi & ~sdbw_pkg::COMMA_BIT;
      if (item_char_r == sdbw_pkg::CH_DOT) begin
        upd.seg_hi = upd.seg_hi | sdbw_pkg::DOT_BIT;
      end else if (item_char_r == sdbw_pkg::CH_COMMA) begin
        upd.seg_hi = upd.seg_hi | sdbw_pkg::DOT_BIT | sdbw_pkg::COMMA_BIT;
      end else begin
        upd.seg_lo = {4'b0000, pat[3:0]} | (cur.seg_lo & sdbw_pkg::TRI_BIT);
        upd.seg_hi = {5'b00000, pat[6:4]};
      end
      if (blink_en_r) begin
        if (in_blink) begin
          upd.blk_lo = upd.seg_lo & sdbw_pkg::TRI_BIT;
          upd.blk_hi = '0;
        end else begin
          upd.blk_lo = upd.seg_lo;
          upd.blk_hi = upd.seg_hi;
        end
      end
    end else begin
      if (item_on_r) begin
        upd.seg_lo = cur.seg_lo | sdbw_pkg::TRI_BIT;
      end else begin
        upd.seg_lo = cur.seg_lo & ~sdbw_pkg::TRI_BIT;
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_RMW;
      ST_RMW:  if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (finish) begin
      out_pos_r <= item_pos_r;
      out_err_r <= item_err_r;
      out_ent_r <= item_err_r ? '0 : upd;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_pos     = out_pos_r;
  assign out_ch.seg_low     = out_ent_r.seg_lo;
  assign out_ch.seg_high    = out_ent_r.seg_hi;
  assign out_ch.blink_low   = out_ent_r.blk_lo;
  assign out_ch.blink_high  = out_ent_r.blk_hi;
  assign out_ch.range_error = out_err_r;

endmodule
`default_nettype wire

@@ hw/rtl/sdbw_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdbw_checker
// Port-level checks of the digit buffer writer, bound to the top level.
// ----------------------------------------------------------------------------
module sdbw_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [sdbw_pkg::POS_W-1:0]  out_pos,
  input wire logic [sdbw_pkg::BYTE_W-1:0] seg_low,
  input wire logic [sdbw_pkg::BYTE_W-1:0] seg_high,
  input wire logic [sdbw_pkg::BYTE_W-1:0] blink_low,
  input wire logic [sdbw_pkg::BYTE_W-1:0] blink_high,
  input wire logic                        range_error
);

  // A pending beat is never dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // One item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted during read-modify-write");

  // Range flag follows the reported position
  a_range_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (range_error == (out_pos >= sdbw_pkg::POS_W'(sdbw_pkg::DIGITS))))
    else $error("range_error does not match out_pos");

  // A bad position reports zero bytes
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && range_error |->
      (seg_low == '0) && (seg_high == '0) && (blink_low == '0) && (blink_high == '0))
    else $error("nonzero bytes on a range error");

  // Nothing comes out the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind seven_segment_digit_buffer_writer_core sdbw_checker u_sdbw_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_pos     (out_ch.out_pos),
  .seg_low     (out_ch.seg_low),
  .seg_high    (out_ch.seg_high),
  .blink_low   (out_ch.blink_low),
  .blink_high  (out_ch.blink_high),
  .range_error (out_ch.range_error)
);
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the seven-segment digit buffer writer. A queue-fed
// driver offers item beats with random gaps, a monitor takes result beats
// with random stalls and compares each one with a digit store model kept in
// the bench. Blink settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import sdbw_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 205;
  localparam int PRINT_CAP   = 100;

  typedef struct packed {
    logic             cmd;
    logic [POS_W-1:0] pos;
    logic [7:0]       ch;
    logic             mark_on;
  } panel_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] seg_lo;
    logic [BYTE_W-1:0] seg_hi;
    logic [BYTE_W-1:0] blk_lo;
    logic [BYTE_W-1:0] blk_hi;
    logic              range_error;
  } digit_view_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;

  sdbw_in_if  in_bus ();
  sdbw_out_if out_bus ();

  seven_segment_digit_buffer_writer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Digit store model and its blink settings
  logic [BYTE_W-1:0] seg_lo_m [DIGITS];
  logic [BYTE_W-1:0] seg_hi_m [DIGITS];
  logic [BYTE_W-1:0] blk_lo_m [DIGITS];
  logic [BYTE_W-1:0] blk_hi_m [DIGITS];
  logic              blink_en_m;
  logic [CFG_W-1:0]  blink_first_m;
  logic [CFG_W-1:0]  blink_last_m;

  panel_item_t pending_items [$];
  digit_view_t expected_views [$];

  int mismatches    = 0;
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int gap_left      = 0;
  int stall_left    = 0;
  int hold_left     = 0;
  int hold_req      = 0;
  int hold_ack      = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** seven_segment_digit_buffer_writer_core: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  function automatic logic [6:0] glyph_of(input logic [7:0] c);
    logic [7:0] k;
    logic [6:0] g;
    k = c;
    // fold upper case onto lower case
    if (c >= 8'h41 && c <= 8'h5A) k = c | 8'h20;
    case (k)
      8'h30: g = 7'h7D;  8'h31: g = 7'h60;  8'h32: g = 7'h3E;  8'h33: g = 7'h7A;
      8'h34: g = 7'h63;  8'h35: g = 7'h5B;  8'h36: g = 7'h5F;  8'h37: g = 7'h71;
      8'h38: g = 7'h7F;  8'h39: g = 7'h7B;
      8'h61: g = 7'h77;  8'h62: g = 7'h4F;  8'h63: g = 7'h1D;  8'h64: g = 7'h6E;
      8'h65: g = 7'h1F;  8'h66: g = 7'h17;  8'h67: g = 7'h5D;  8'h68: g = 7'h67;
      8'h69: g = 7'h40;  8'h6A: g = 7'h6C;  8'h6B: g = 7'h07;  8'h6C: g = 7'h0D;
      8'h6D: g = 7'h56;  8'h6E: g = 7'h46;  8'h6F: g = 7'h4E;  8'h70: g = 7'h37;
      8'h71: g = 7'h73;  8'h72: g = 7'h06;  8'h73: g = 7'h5B;  8'h74: g = 7'h0F;
      8'h75: g = 7'h6D;  8'h76: g = 7'h4C;  8'h77: g = 7'h5C;  8'h78: g = 7'h1A;
      8'h79: g = 7'h6B;  8'h7A: g = 7'h3E;
      8'h5F: g = 7'h08;  // underscore
      8'h2D: g = 7'h02;  // minus
      8'h20: g = 7'h00;  // space
      8'h01: g = 7'h08;  // cursor
      8'h00: g = 7'h00;  // NUL
      default: g = 7'h18;
    endcase
    return g;
  endfunction

  // Apply one item to the model and return the digit as it must read back
  function automatic digit_view_t update_digit(input panel_item_t it);
    digit_view_t v;
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
    logic [BYTE_W-1:0] tri_keep;
    logic [6:0] g;
    int p;
    v = '0;
    v.pos = it.pos;
    p = it.pos;
    if (p >= DIGITS) begin
      v.range_error = 1'b1;
    end else begin
      if (it.cmd == CMD_CHAR) begin
        lo = seg_lo_m[p];
        hi = seg_hi_m[p] & ~COMMA_BIT;
        tri_keep = lo & TRI_BIT;
        g = glyph_of(it.ch);
        if (it.ch == CH_DOT) begin
          hi = hi | DOT_BIT;
        end else if (it.ch == CH_COMMA) begin
          hi = hi | DOT_BIT | COMMA_BIT;
        end else begin
          lo = {4'b0, g[3:0]} | tri_keep;
          hi = {5'b0, g[6:4]};
        end
        seg_lo_m[p] = lo;
        seg_hi_m[p] = hi;
        if (blink_en_m) begin
          if (p >= blink_first_m && p <= blink_last_m) begin
            blk_lo_m[p] = lo & TRI_BIT;
            blk_hi_m[p] = '0;
          end else begin
            blk_lo_m[p] = lo;
            blk_hi_m[p] = hi;
          end
        end
      end else if (it.mark_on) begin
        seg_lo_m[p] = seg_lo_m[p] | TRI_BIT;
      end else begin
        seg_lo_m[p] = seg_lo_m[p] & ~TRI_BIT;
      end
      v.seg_lo = seg_lo_m[p];
      v.seg_hi = seg_hi_m[p];
      v.blk_lo = blk_lo_m[p];
      v.blk_hi = blk_hi_m[p];
    end
    return v;
  endfunction

  // Driver: predict on each accepted beat, then offer the next pending item
  always @(posedge clk) begin : drv
    panel_item_t nxt;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready)
        expected_views.push_back(update_digit({in_bus.cmd, in_bus.digit_pos,
                                               in_bus.char_code, in_bus.mark_on}));
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_bus.valid <= 1'b0;
        end else if (pending_items.size() != 0 && $urandom_range(99) < src_idle_pct) begin
          gap_left <= $urandom_range(16);
          in_bus.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          nxt = pending_items.pop_front();
          in_bus.cmd       <= nxt.cmd;
          in_bus.digit_pos <= nxt.pos;
          in_bus.char_code <= nxt.ch;
          in_bus.mark_on   <= nxt.mark_on;
          in_bus.valid     <= 1'b1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat, drive ready with stalls and the long hold
  always @(posedge clk) begin : mon
    digit_view_t got;
    digit_view_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got = {out_bus.out_pos, out_bus.seg_low, out_bus.seg_high,
               out_bus.blink_low, out_bus.blink_high, out_bus.range_error};
        if (expected_views.size() == 0) begin
          report_mismatch("beat with nothing expected, pos", got.pos, 0);
        end else begin
          want = expected_views.pop_front();
          if (got.pos !== want.pos) report_mismatch("out_pos", got.pos, want.pos);
          if (got.seg_lo !== want.seg_lo) report_mismatch("seg_low", got.seg_lo, want.seg_lo);
          if (got.seg_hi !== want.seg_hi) report_mismatch("seg_high", got.seg_hi, want.seg_hi);
          if (got.blk_lo !== want.blk_lo) report_mismatch("blink_low", got.blk_lo, want.blk_lo);
          if (got.blk_hi !== want.blk_hi) report_mismatch("blink_high", got.blk_hi, want.blk_hi);
          if (got.range_error !== want.range_error)
            report_mismatch("range_error", got.range_error, want.range_error);
        end
      end
      if (hold_ack != hold_req) begin
        hold_ack <= hold_req;
        hold_left <= HOLD_CYCLES;
        out_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_bus.ready <= 1'b0;
      end else if ($urandom_range(99) < sink_idle_pct) begin
        stall_left <= $urandom_range(16);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_blink(input logic en, input int first, input int last);
    write_reg(CFG_BLINK_ENABLE, {4'b0, en});
    write_reg(CFG_BLINK_FIRST, first[CFG_W-1:0]);
    write_reg(CFG_BLINK_LAST, last[CFG_W-1:0]);
    blink_en_m    = en;
    blink_first_m = first[CFG_W-1:0];
    blink_last_m  = last[CFG_W-1:0];
  endtask

  // Hold off until every offered item has its result back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_bus.valid || expected_views.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic queue_item(input logic cmd, input int pos, input logic [7:0] ch,
                            input logic on);
    panel_item_t it;
    it.cmd = cmd;
    it.pos = pos[POS_W-1:0];
    it.ch = ch;
    it.mark_on = on;
    pending_items.push_back(it);
  endtask

  function automatic panel_item_t random_item(input logic [POS_W-1:0] prev_pos);
    panel_item_t it;
    int sel;
    int r;
    it.cmd = ($urandom_range(3) == 0) ? CMD_TRIANGLE : CMD_CHAR;
    sel = $urandom_range(99);
    if (sel < 25) it.pos = prev_pos;
    else if (sel < 35) it.pos = $urandom_range(63, DIGITS);
    else it.pos = $urandom_range(DIGITS - 1);
    sel = $urandom_range(99);
    if (sel < 35) begin
      r = $urandom_range(61);
      if (r < 10) it.ch = 8'h30 + r;
      else if (r < 36) it.ch = 8'h41 + (r - 10);
      else it.ch = 8'h61 + (r - 36);
    end else if (sel < 50) begin
      it.ch = $urandom_range(1) ? CH_DOT : CH_COMMA;
    end else if (sel < 60) begin
      case ($urandom_range(4))
        0: it.ch = 8'h5F;
        1: it.ch = 8'h2D;
        2: it.ch = 8'h20;
        3: it.ch = 8'h01;
        default: it.ch = 8'h00;
      endcase
    end else begin
      it.ch = $urandom_range(255);
    end
    it.mark_on = $urandom_range(1);
    return it;
  endfunction

  task automatic run_phase(input int n, input int src_pct, input int sink_pct,
                           input bit long_hold);
    panel_item_t it;
    logic [POS_W-1:0] last_pos;
    last_pos = '0;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    if (long_hold) begin
      // the sender keeps offering while the receiver holds off
      @(posedge clk);
      hold_req <= hold_req + 1;
      @(negedge clk);
    end
    for (int i = 0; i < n; i++) begin
      it = random_item(last_pos);
      last_pos = it.pos;
      pending_items.push_back(it);
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.cmd = CMD_CHAR;
    in_bus.digit_pos = '0;
    in_bus.char_code = '0;
    in_bus.mark_on = 1'b0;
    out_bus.ready = 1'b0;
    for (int i = 0; i < DIGITS; i++) begin
      seg_lo_m[i] = '0;
      seg_hi_m[i] = '0;
      blk_lo_m[i] = '0;
      blk_hi_m[i] = '0;
    end
    blink_en_m = 1'b0;
    blink_first_m = '0;
    blink_last_m = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every glyph class, marks, triangle, blink range edges, bad positions
    set_blink(1'b1, 2, 5);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    queue_item(CMD_CHAR, 0, 8'h30, 1'b0);
    queue_item(CMD_TRIANGLE, 0, 8'hFF, 1'b1);
    queue_item(CMD_CHAR, 0, 8'h38, 1'b1);
    queue_item(CMD_CHAR, 0, CH_DOT, 1'b0);
    queue_item(CMD_CHAR, 0, CH_COMMA, 1'b0);
    queue_item(CMD_CHAR, 1, 8'h41, 1'b0);
    queue_item(CMD_CHAR, 1, 8'h7A, 1'b0);
    queue_item(CMD_CHAR, 2, 8'h5F, 1'b0);
    queue_item(CMD_CHAR, 3, 8'h2D, 1'b0);
    queue_item(CMD_CHAR, 4, 8'h20, 1'b0);
    queue_item(CMD_CHAR, 5, 8'h01, 1'b0);
    queue_item(CMD_CHAR, 6, 8'h00, 1'b0);
    queue_item(CMD_CHAR, 7, 8'hFF, 1'b0);
    queue_item(CMD_CHAR, 23, 8'h80, 1'b0);
    queue_item(CMD_TRIANGLE, 23, 8'h00, 1'b1);
    queue_item(CMD_CHAR, 3, CH_COMMA, 1'b0);
    queue_item(CMD_TRIANGLE, 3, 8'h00, 1'b1);
    queue_item(CMD_CHAR, 3, 8'h5A, 1'b0);
    queue_item(CMD_TRIANGLE, 3, 8'h55, 1'b0);
    queue_item(CMD_CHAR, 24, 8'h4D, 1'b0);
    queue_item(CMD_TRIANGLE, 63, 8'h00, 1'b1);
    queue_item(CMD_CHAR, 23, CH_DOT, 1'b0);
    queue_item(CMD_CHAR, 22, 8'h71, 1'b0);
    queue_item(CMD_CHAR, 21, 8'h7F, 1'b0);
    wait_drained();

    // Random phases over blink settings, extremes first
    set_blink(1'b1, 0, 23);
    run_phase(PHASE_ITEMS, 20, 20, 1'b0);
    set_blink(1'b1, 23, 0);
    run_phase(PHASE_ITEMS, 30, 10, 1'b0);
    set_blink(1'b0, 5, 9);
    run_phase(PHASE_ITEMS, 10, 30, 1'b0);
    set_blink(1'b1, 0, 0);
    run_phase(PHASE_ITEMS, 0, 0, 1'b1);
    set_blink(1'b1, 23, 23);
    run_phase(PHASE_ITEMS, 40, 40, 1'b0);
    set_blink(1'b1, $urandom_range(23), $urandom_range(23));
    run_phase(PHASE_ITEMS, 15, 15, 1'b0);
    set_blink($urandom_range(1), $urandom_range(23), $urandom_range(23));
    run_phase(PHASE_ITEMS, 0, 25, 1'b0);
    // no idling in the last stretch
    set_blink(1'b1, $urandom_range(11), $urandom_range(23, 12));
    run_phase(PHASE_ITEMS, 0, 0, 1'b0);

    repeat (8) @(negedge clk);
    if (expected_views.size() != 0)
      report_mismatch("results never delivered", expected_views.size(), 0);
    if (mismatches == 0) begin
      $display("** seven_segment_digit_buffer_writer_core: PASSED **");
    end else begin
      $display("** seven_segment_digit_buffer_writer_core: FAILED **");
    end
    $finish;
  end

endmodule
